// File: sv/sphk_pkg.sv
// ----------------------------------------------------------------------------
// sphk_pkg
// Shared types, register codes, reset values and saturation helper for the
// cubic spline kernel unit.
// ----------------------------------------------------------------------------
package sphk_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned MagW  = WordW + 4;
  localparam int unsigned HiW   = MagW - WordW;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] InvHalfSupportRst = 32'd65536;
  localparam logic [WordW-1:0] NormFactorRst     = 32'd7451;
  localparam logic [WordW-1:0] GradFactorRst     = 32'd7451;

  localparam logic [WordW-1:0] SignedMax = 32'h7FFF_FFFF;
  localparam logic [WordW-1:0] SignedMin = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    RegInvHalfSupport = 2'd0,
    RegNormFactor     = 2'd1,
    RegGradFactor     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic le_one;
    logic in_sup;
  } pow_ctl_t;

  typedef struct packed {
    logic valid;
    logic fneg;
    logic w_clip;
  } fac_ctl_t;

  typedef struct packed {
    logic             clip;
    logic [WordW-1:0] val;
  } sat_t;

  // pack a sign and magnitude into a saturated signed word
  function automatic sat_t sat_pack(logic neg, logic big, logic [WordW-1:0] mag);
    sat_t res;
    logic over;
    over = neg ? (big || (mag[WordW-1] && (|mag[WordW-2:0])))
               : (big || mag[WordW-1]);
    res.clip = over;
    if (neg) begin
      res.val = over ? SignedMin : (WordW'(0) - mag);
    end else begin
      res.val = over ? SignedMax : mag;
    end
    return res;
  endfunction

endpackage

// File: sv/sph_cubic_spline_kernel_unit.sv
// ----------------------------------------------------------------------------
// sph_cubic_spline_kernel_unit
// 2-D cubic spline smoothing kernel: value, radial slope and gradient.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive distance_i, offset_x_i, offset_y_i and raise start; the item
//   transfers at a rising edge with start high and busy low. busy is high
//   only from reset until the first clock after reset is released.
//   Output: done_o is high for one cycle with kernel_value_o, radial_slope_o,
//   grad_x_o, grad_y_o and clipped_o; that cycle is the transfer. The
//   receiver cannot stall, so no result is ever held back.
//   Pipeline: seven register stages (scale, square, cube, polynomial, factor
//   multiply, gradient partial products, saturation) lie between the input
//   transfer and the result.
//   Throughput: one item per clock, back to back.
//   Configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i write one register per
//   edge (0 inverse half support, 1 normalization, 2 slope factor; 3 is
//   dropped). Write only while no item is in flight.
//   Reset: asynchronous, clears the stage valid bits and loads the register
//   defaults.
// ----------------------------------------------------------------------------
module sph_cubic_spline_kernel_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we_i,
  input  logic [sphk_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sphk_pkg::WordW-1:0]        cfg_wdata_i,
  input  logic [sphk_pkg::WordW-1:0]        distance_i,
  input  logic signed [sphk_pkg::WordW-1:0] offset_x_i,
  input  logic signed [sphk_pkg::WordW-1:0] offset_y_i,
  output logic                              done_o,
  output logic [sphk_pkg::WordW-1:0]        kernel_value_o,
  output logic signed [sphk_pkg::WordW-1:0] radial_slope_o,
  output logic signed [sphk_pkg::WordW-1:0] grad_x_o,
  output logic signed [sphk_pkg::WordW-1:0] grad_y_o,
  output logic                              clipped_o
);
  import sphk_pkg::*;

  logic [WordW-1:0] inv_q, norm_q, grad_q;
  logic             ready_q;
  logic             in_xfer;

  pow_ctl_t             pctl;
  logic [FRAC_BITS+3:0] s2c;
  logic [FRAC_BITS:0]   s1c;
  logic [FRAC_BITS+2:0] s2s;
  logic [FRAC_BITS:0]   s1s;
  logic [WordW-1:0]     ox3, oy3, ox5, oy5;

  fac_ctl_t         fctl;
  logic [WordW-1:0] w5;
  logic [MagW-1:0]  fmag5;

  logic [WordW-1:0] rs, gx, gy;

  assign busy    = !ready_q;
  assign in_xfer = start && ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      inv_q   <= InvHalfSupportRst;
      norm_q  <= NormFactorRst;
      grad_q  <= GradFactorRst;
    end else begin
      ready_q <= 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          RegInvHalfSupport: inv_q  <= cfg_wdata_i;
          RegNormFactor:     norm_q <= cfg_wdata_i;
          RegGradFactor:     grad_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  sphk_pow #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pow (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_xfer),
    .inv_i      (inv_q),
    .distance_i (distance_i),
    .ox_i       (offset_x_i),
    .oy_i       (offset_y_i),
    .ctl_o      (pctl),
    .s2c_o      (s2c),
    .s1c_o      (s1c),
    .s2s_o      (s2s),
    .s1s_o      (s1s),
    .ox_o       (ox3),
    .oy_o       (oy3)
  );

  sphk_fac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pctl),
    .s2c_i  (s2c),
    .s1c_i  (s1c),
    .s2s_i  (s2s),
    .s1s_i  (s1s),
    .ox_i   (ox3),
    .oy_i   (oy3),
    .norm_i (norm_q),
    .grad_i (grad_q),
    .ctl_o  (fctl),
    .w_o    (w5),
    .fmag_o (fmag5),
    .ox_o   (ox5),
    .oy_o   (oy5)
  );

  sphk_grad #(
    .FRAC_BITS (FRAC_BITS)
  ) u_grad (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (fctl),
    .w_i            (w5),
    .fmag_i         (fmag5),
    .ox_i           (ox5),
    .oy_i           (oy5),
    .done_o         (done_o),
    .kernel_value_o (kernel_value_o),
    .radial_slope_o (rs),
    .grad_x_o       (gx),
    .grad_y_o       (gy),
    .clipped_o      (clipped_o)
  );

  assign radial_slope_o = rs;
  assign grad_x_o       = gx;
  assign grad_y_o       = gy;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##7 done_o)
    else $error("result did not appear seven cycles after transfer");
`endif

endmodule

// File: sv/sphk_pow.sv
// ----------------------------------------------------------------------------
// sphk_pow
// Scaled distance and truncated square and cube terms, three register stages.
// ----------------------------------------------------------------------------
module sphk_pow #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [sphk_pkg::WordW-1:0]     inv_i,
  input  logic [sphk_pkg::WordW-1:0]     distance_i,
  input  logic [sphk_pkg::WordW-1:0]     ox_i,
  input  logic [sphk_pkg::WordW-1:0]     oy_i,
  output sphk_pkg::pow_ctl_t             ctl_o,
  output logic [FRAC_BITS+3:0]           s2c_o,
  output logic [FRAC_BITS:0]             s1c_o,
  output logic [FRAC_BITS+2:0]           s2s_o,
  output logic [FRAC_BITS:0]             s1s_o,
  output logic [sphk_pkg::WordW-1:0]     ox_o,
  output logic [sphk_pkg::WordW-1:0]     oy_o
);
  import sphk_pkg::*;

  localparam int unsigned ProdW = 2 * WordW;
  localparam int unsigned RW    = ProdW - FRAC_BITS;
  localparam int unsigned S2W   = FRAC_BITS + 2;
  localparam int unsigned S1W   = FRAC_BITS + 1;
  localparam int unsigned S2SW  = FRAC_BITS + 3;
  localparam int unsigned S2CW  = FRAC_BITS + 4;

  localparam logic [RW-1:0] OneR = {{(RW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [RW-1:0] TwoR = {{(RW-FRAC_BITS-2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}};

  logic [ProdW-1:0] prod;
  logic [RW-1:0]    r_d, r_q;
  logic             v1_q;
  logic [WordW-1:0] ox1_q, oy1_q, ox2_q, oy2_q, ox3_q, oy3_q;

  logic [RW-1:0]    diff2, diff1;
  logic [S2W-1:0]   s2_d, s2b_q;
  logic [S1W-1:0]   s1_d, s1b_q;
  logic [2*S2W-1:0] sq2;
  logic [2*S1W-1:0] sq1;
  logic [S2SW-1:0]  s2s_d, s2s_q, s2s3_q;
  logic [S1W-1:0]   s1s_d, s1s_q, s1s3_q;
  pow_ctl_t         ctl2_d, ctl2_q, ctl3_q;

  logic [S2SW+S2W-1:0] cu2;
  logic [2*S1W-1:0]    cu1;
  logic [S2CW-1:0]     s2c_q;
  logic [S1W-1:0]      s1c_q;

  assign prod = ProdW'(distance_i) * ProdW'(inv_i);
  assign r_d  = prod[ProdW-1:FRAC_BITS];

  assign diff2 = TwoR - r_q;
  assign diff1 = OneR - r_q;
  assign s2_d  = diff2[S2W-1:0];
  assign s1_d  = diff1[S1W-1:0];
  assign sq2   = (2*S2W)'(s2_d) * (2*S2W)'(s2_d);
  assign sq1   = (2*S1W)'(s1_d) * (2*S1W)'(s1_d);
  assign s2s_d = sq2[FRAC_BITS +: S2SW];
  assign s1s_d = sq1[FRAC_BITS +: S1W];

  always_comb begin
    ctl2_d.valid  = v1_q;
    ctl2_d.le_one = (r_q <= OneR);
    ctl2_d.in_sup = (r_q <= TwoR);
  end

  assign cu2 = (S2SW+S2W)'(s2s_q) * (S2SW+S2W)'(s2b_q);
  assign cu1 = (2*S1W)'(s1s_q) * (2*S1W)'(s1b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      v1_q   <= valid_i;
      ctl2_q <= ctl2_d;
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    ox1_q  <= ox_i;
    oy1_q  <= oy_i;
    s2b_q  <= s2_d;
    s1b_q  <= s1_d;
    s2s_q  <= s2s_d;
    s1s_q  <= s1s_d;
    ox2_q  <= ox1_q;
    oy2_q  <= oy1_q;
    s2c_q  <= cu2[FRAC_BITS +: S2CW];
    s1c_q  <= cu1[FRAC_BITS +: S1W];
    s2s3_q <= s2s_q;
    s1s3_q <= s1s_q;
    ox3_q  <= ox2_q;
    oy3_q  <= oy2_q;
  end

  assign ctl_o = ctl3_q;
  assign s2c_o = s2c_q;
  assign s1c_o = s1c_q;
  assign s2s_o = s2s3_q;
  assign s1s_o = s1s3_q;
  assign ox_o  = ox3_q;
  assign oy_o  = oy3_q;

endmodule

// File: sv/sphk_fac.sv
// ----------------------------------------------------------------------------
// sphk_fac
// Kernel polynomial and slope, then scaling by the normalization and slope
// factors, two register stages.
// ----------------------------------------------------------------------------
module sphk_fac #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sphk_pkg::pow_ctl_t             ctl_i,
  input  logic [FRAC_BITS+3:0]           s2c_i,
  input  logic [FRAC_BITS:0]             s1c_i,
  input  logic [FRAC_BITS+2:0]           s2s_i,
  input  logic [FRAC_BITS:0]             s1s_i,
  input  logic [sphk_pkg::WordW-1:0]     ox_i,
  input  logic [sphk_pkg::WordW-1:0]     oy_i,
  input  logic [sphk_pkg::WordW-1:0]     norm_i,
  input  logic [sphk_pkg::WordW-1:0]     grad_i,
  output sphk_pkg::fac_ctl_t             ctl_o,
  output logic [sphk_pkg::WordW-1:0]     w_o,
  output logic [sphk_pkg::MagW-1:0]      fmag_o,
  output logic [sphk_pkg::WordW-1:0]     ox_o,
  output logic [sphk_pkg::WordW-1:0]     oy_o
);
  import sphk_pkg::*;

  localparam int unsigned PolyW  = FRAC_BITS + 4;
  localparam int unsigned DiffW  = FRAC_BITS + 5;
  localparam int unsigned SlopeW = FRAC_BITS + 6;
  localparam int unsigned ProdW  = WordW + PolyW;

  logic [DiffW-1:0]  pdiff;
  logic [PolyW-1:0]  poly_d, poly_q;
  logic [SlopeW-1:0] t12, t3, slope_s, smag_full;
  logic              sneg_d, sneg_q;
  logic [PolyW-1:0]  smag_d, smag_q;
  logic              v4_q;
  logic [WordW-1:0]  ox4_q, oy4_q, ox5_q, oy5_q;

  logic [ProdW-1:0]  wp, fp;
  logic [MagW-1:0]   wmag, fmag_d, fmag_q;
  logic [WordW-1:0]  w_q;
  fac_ctl_t          ctl_d, ctl_q;

  always_comb begin
    pdiff = {1'b0, s2c_i} - (ctl_i.le_one ? {2'b00, s1c_i, 2'b00} : DiffW'(0));
    poly_d = (!ctl_i.in_sup || pdiff[DiffW-1]) ? '0 : pdiff[PolyW-1:0];

    t12 = (SlopeW'(s1s_i) << 3) + (SlopeW'(s1s_i) << 2);
    t3  = (SlopeW'(s2s_i) << 1) + SlopeW'(s2s_i);
    slope_s   = ctl_i.le_one ? (t12 - t3) : (SlopeW'(0) - t3);
    sneg_d    = ctl_i.in_sup && slope_s[SlopeW-1];
    smag_full = slope_s[SlopeW-1] ? (SlopeW'(0) - slope_s) : slope_s;
    smag_d    = ctl_i.in_sup ? smag_full[PolyW-1:0] : '0;
  end

  assign wp     = ProdW'(norm_i) * ProdW'(poly_q);
  assign fp     = ProdW'(grad_i) * ProdW'(smag_q);
  assign wmag   = wp[FRAC_BITS +: MagW];
  assign fmag_d = fp[FRAC_BITS +: MagW];

  always_comb begin
    ctl_d.valid  = v4_q;
    ctl_d.fneg   = sneg_q && (fmag_d != '0);
    ctl_d.w_clip = |wmag[MagW-1:WordW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q  <= 1'b0;
      ctl_q <= '0;
    end else begin
      v4_q  <= ctl_i.valid;
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    poly_q <= poly_d;
    smag_q <= smag_d;
    sneg_q <= sneg_d;
    ox4_q  <= ox_i;
    oy4_q  <= oy_i;
    w_q    <= ctl_d.w_clip ? '1 : wmag[WordW-1:0];
    fmag_q <= fmag_d;
    ox5_q  <= ox4_q;
    oy5_q  <= oy4_q;
  end

  assign ctl_o  = ctl_q;
  assign w_o    = w_q;
  assign fmag_o = fmag_q;
  assign ox_o   = ox5_q;
  assign oy_o   = oy5_q;

`ifndef NO_ASSERTIONS
  a_fneg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.valid && ctl_q.fneg) |-> (fmag_q != '0))
    else $error("negative slope with zero magnitude");
`endif

endmodule

// File: sv/sphk_grad.sv
// ----------------------------------------------------------------------------
// sphk_grad
// Gradient products of the slope with each offset component, saturation and
// result registers, two register stages.
// ----------------------------------------------------------------------------
module sphk_grad #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sphk_pkg::fac_ctl_t             ctl_i,
  input  logic [sphk_pkg::WordW-1:0]     w_i,
  input  logic [sphk_pkg::MagW-1:0]      fmag_i,
  input  logic [sphk_pkg::WordW-1:0]     ox_i,
  input  logic [sphk_pkg::WordW-1:0]     oy_i,
  output logic                           done_o,
  output logic [sphk_pkg::WordW-1:0]     kernel_value_o,
  output logic [sphk_pkg::WordW-1:0]     radial_slope_o,
  output logic [sphk_pkg::WordW-1:0]     grad_x_o,
  output logic [sphk_pkg::WordW-1:0]     grad_y_o,
  output logic                           clipped_o
);
  import sphk_pkg::*;

  localparam int unsigned LoW   = 2 * WordW;
  localparam int unsigned HiPW  = HiW + WordW;
  localparam int unsigned FullW = HiPW + WordW;

  logic [WordW-1:0] omag_x, omag_y;
  logic [LoW-1:0]   lo_x_d, lo_y_d, lo_x_q, lo_y_q;
  logic [HiPW-1:0]  hi_x_d, hi_y_d, hi_x_q, hi_y_q;
  logic             gneg_x_q, gneg_y_q;
  sat_t             fsat_d, fsat_q;
  logic [WordW-1:0] w6_q;
  fac_ctl_t         ctl6_q;

  logic [FullW-1:0] full_x, full_y;
  sat_t             gx, gy;

  logic             done_q, clip_q;
  logic [WordW-1:0] kv_q, rs_q, gx_q, gy_q;

  assign omag_x = ox_i[WordW-1] ? (WordW'(0) - ox_i) : ox_i;
  assign omag_y = oy_i[WordW-1] ? (WordW'(0) - oy_i) : oy_i;
  assign lo_x_d = LoW'(fmag_i[WordW-1:0]) * LoW'(omag_x);
  assign lo_y_d = LoW'(fmag_i[WordW-1:0]) * LoW'(omag_y);
  assign hi_x_d = HiPW'(fmag_i[MagW-1:WordW]) * HiPW'(omag_x);
  assign hi_y_d = HiPW'(fmag_i[MagW-1:WordW]) * HiPW'(omag_y);
  assign fsat_d = sat_pack(ctl_i.fneg, |fmag_i[MagW-1:WordW], fmag_i[WordW-1:0]);

  assign full_x = {hi_x_q, {WordW{1'b0}}} + FullW'(lo_x_q);
  assign full_y = {hi_y_q, {WordW{1'b0}}} + FullW'(lo_y_q);
  assign gx = sat_pack(gneg_x_q, |full_x[FullW-1:FRAC_BITS+WordW],
                       full_x[FRAC_BITS +: WordW]);
  assign gy = sat_pack(gneg_y_q, |full_y[FullW-1:FRAC_BITS+WordW],
                       full_y[FRAC_BITS +: WordW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl6_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl6_q <= ctl_i;
      done_q <= ctl6_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_x_q   <= lo_x_d;
    lo_y_q   <= lo_y_d;
    hi_x_q   <= hi_x_d;
    hi_y_q   <= hi_y_d;
    gneg_x_q <= ctl_i.fneg ^ ox_i[WordW-1];
    gneg_y_q <= ctl_i.fneg ^ oy_i[WordW-1];
    fsat_q   <= fsat_d;
    w6_q     <= w_i;
    kv_q     <= w6_q;
    rs_q     <= fsat_q.val;
    gx_q     <= gx.val;
    gy_q     <= gy.val;
    clip_q   <= ctl6_q.w_clip | fsat_q.clip | gx.clip | gy.clip;
  end

  assign done_o         = done_q;
  assign kernel_value_o = kv_q;
  assign radial_slope_o = rs_q;
  assign grad_x_o       = gx_q;
  assign grad_y_o       = gy_q;
  assign clipped_o      = clip_q;

`ifndef NO_ASSERTIONS
  a_zero_slope_zero_grad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rs_q == '0) |-> (gx_q == '0 && gy_q == '0))
    else $error("gradient nonzero with zero slope");
  a_clip_needs_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && kv_q != '1 && rs_q != SignedMax && rs_q != SignedMin &&
     gx_q != SignedMax && gx_q != SignedMin &&
     gy_q != SignedMax && gy_q != SignedMin) |-> !clip_q)
    else $error("clip flag set without a saturated value");
`endif

endmodule

// File: test/sph_cubic_spline_kernel_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sph_cubic_spline_kernel_unit_test
// Self-checking bench for the 2-D cubic spline kernel unit. Pair distances and
// offsets are sent over the start/busy port. Every transfer is scored against
// a fixed-point predictor that tracks the register settings. Runs edge and
// saturation cases first, then random pairs under a series of register
// settings, with random gaps on the input side under all but the last one.
// ----------------------------------------------------------------------------
module sph_cubic_spline_kernel_unit_test;
  import sphk_pkg::*;

  localparam int FracBits = 16;
  localparam logic [63:0] One = 64'd1 << FracBits;
  localparam int Limit = 200000;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  localparam logic [31:0] EdgeDist [11] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_8000, 32'h0000_FFFF, 32'h0001_0000,
    32'h0001_0001, 32'h0001_8000, 32'h0001_FFFF, 32'h0002_0000, 32'h0002_0001,
    32'hFFFF_FFFF
  };
  localparam logic [31:0] EdgeOffset [6] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h0001_0000
  };

  typedef struct packed {
    logic [31:0] distance;
    logic [31:0] offset_x;
    logic [31:0] offset_y;
  } pair_t;

  typedef struct packed {
    logic [31:0] kernel_value;
    logic [31:0] radial_slope;
    logic [31:0] grad_x;
    logic [31:0] grad_y;
    logic        clipped;
  } kernel_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;
  logic [31:0] distance = '0;
  logic [31:0] offset_x = '0;
  logic [31:0] offset_y = '0;
  logic done;
  logic [31:0] kernel_value;
  logic [31:0] radial_slope;
  logic [31:0] grad_x;
  logic [31:0] grad_y;
  logic clipped;

  logic [31:0] inv_reg = InvHalfSupportRst;
  logic [31:0] norm_reg = NormFactorRst;
  logic [31:0] grad_reg = GradFactorRst;

  pair_t pair_q[$];
  kernel_result_t kernel_q[$];
  pair_t next_pair;
  kernel_result_t want;
  kernel_result_t got;
  logic go;
  logic gaps_on = 1'b1;
  int gap_left = 0;
  int fault_count = 0;
  int cycle_count = 0;

  sph_cubic_spline_kernel_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .distance_i     (distance),
    .offset_x_i     (offset_x),
    .offset_y_i     (offset_y),
    .done_o         (done),
    .kernel_value_o (kernel_value),
    .radial_slope_o (radial_slope),
    .grad_x_o       (grad_x),
    .grad_y_o       (grad_y),
    .clipped_o      (clipped)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [32:0] saturate_signed(logic neg, logic [63:0] mag);
    logic over;
    logic [31:0] val;
    if (neg) begin
      over = mag > 64'h8000_0000;
      val = over ? SignedMin : 32'd0 - mag[31:0];
    end else begin
      over = mag > 64'h7FFF_FFFF;
      val = over ? SignedMax : mag[31:0];
    end
    return {over, val};
  endfunction

  function automatic logic [32:0] scale_offset(logic fneg, logic [63:0] fmag,
                                               logic [31:0] off);
    logic [63:0] omag;
    logic [127:0] prod;
    omag = off[31] ? 64'h1_0000_0000 - {32'd0, off} : {32'd0, off};
    prod = ({64'd0, fmag} * {64'd0, omag}) >> FracBits;
    return saturate_signed(fneg ^ off[31],
                           (prod > 128'hFFFF_FFFF) ? 64'h1_0000_0000 : prod[63:0]);
  endfunction

  function automatic kernel_result_t predict_kernel(pair_t p);
    logic [63:0] r, s2, s2sq, s2cu, s1, s1sq, s1cu, w, fmag;
    longint poly, slope;
    logic fneg;
    logic clip;
    logic [32:0] sat;
    kernel_result_t res;
    res = '0;
    clip = 1'b0;
    r = ({32'd0, p.distance} * {32'd0, inv_reg}) >> FracBits;
    if (r <= 2 * One) begin
      s2 = 2 * One - r;
      s2sq = (s2 * s2) >> FracBits;
      s2cu = (s2sq * s2) >> FracBits;
      if (r > One) begin
        poly = longint'(s2cu);
        slope = -3 * longint'(s2sq);
      end else begin
        s1 = One - r;
        s1sq = (s1 * s1) >> FracBits;
        s1cu = (s1sq * s1) >> FracBits;
        poly = longint'(s2cu) - 4 * longint'(s1cu);
        slope = 12 * longint'(s1sq) - 3 * longint'(s2sq);
      end
      if (poly < 0) poly = 0;
      w = ({32'd0, norm_reg} * 64'(poly)) >> FracBits;
      if (w > 64'hFFFF_FFFF) begin
        clip = 1'b1;
        w = 64'hFFFF_FFFF;
      end
      fneg = slope < 0;
      fmag = fneg ? 64'(-slope) : 64'(slope);
      fmag = ({32'd0, grad_reg} * fmag) >> FracBits;
      if (fmag == 0) fneg = 1'b0;
      res.kernel_value = w[31:0];
      sat = saturate_signed(fneg, fmag);
      clip |= sat[32];
      res.radial_slope = sat[31:0];
      sat = scale_offset(fneg, fmag, p.offset_x);
      clip |= sat[32];
      res.grad_x = sat[31:0];
      sat = scale_offset(fneg, fmag, p.offset_y);
      clip |= sat[32];
      res.grad_y = sat[31:0];
      res.clipped = clip;
    end
    return res;
  endfunction

  function automatic logic [31:0] random_offset();
    case ($urandom_range(0, 3))
      0, 1: return $urandom();
      2: return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
      default: return EdgeOffset[$urandom_range(0, 5)];
    endcase
  endfunction

  task automatic add_directed();
    for (int i = 0; i < 11; i++) begin
      pair_q.push_back('{EdgeDist[i], EdgeOffset[i % 6], EdgeOffset[(i + 3) % 6]});
    end
  endtask

  task automatic add_random(int n);
    logic [63:0] target;
    logic [63:0] span;
    pair_t p;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        8, 9: target = 64'($urandom_range(0, 3)) << FracBits;
        default: target = 64'($urandom_range(0, 32'h2_8000));
      endcase
      target = target + 64'($urandom_range(0, 2)) - 64'd1;
      span = ((target << FracBits) + 64'(inv_reg) - 64'd1) / 64'(inv_reg);
      p.distance = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
      if ($urandom_range(0, 7) == 0) p.distance = $urandom();
      p.offset_x = random_offset();
      p.offset_y = random_offset();
      pair_q.push_back(p);
    end
  endtask

  // call just after a rising edge; leaves the write enable high
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    case (idx)
      RegInvHalfSupport: inv_reg = value;
      RegNormFactor: norm_reg = value;
      RegGradFactor: grad_reg = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pair_q.size() != 0 || start || kernel_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // driver: hold a pair until its transfer, then advance or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      go = start;
      if (start && !busy) begin
        kernel_q.push_back(predict_kernel('{distance, offset_x, offset_y}));
        go = 1'b0;
      end
      if (!go) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pair_q.size() != 0) begin
          next_pair = pair_q.pop_front();
          distance <= next_pair.distance;
          offset_x <= next_pair.offset_x;
          offset_y <= next_pair.offset_y;
          go = 1'b1;
          if (gaps_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 6);
        end
      end
      start <= go;
    end
  end

  // monitor: score every result strobe against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done) begin
      got = '{kernel_value, radial_slope, grad_x, grad_y, clipped};
      if (kernel_q.size() == 0) begin
        $display("%0t: result with nothing pending: %h", $time, got);
        fault_count++;
      end else begin
        want = kernel_q.pop_front();
        if (got !== want) begin
          $display("%0t: W exp %h act %h, F exp %h act %h, gx exp %h act %h, gy exp %h act %h, clip exp %b act %b",
                   $time, want.kernel_value, got.kernel_value, want.radial_slope,
                   got.radial_slope, want.grad_x, got.grad_x, want.grad_y, got.grad_y,
                   want.clipped, got.clipped);
          fault_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < Limit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("sph_cubic_spline_kernel_unit: mismatch");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_directed();
    wait_drained();

    write_reg(RegNormFactor, 32'hFFFF_FFFF);
    write_reg(RegGradFactor, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    add_directed();
    add_random(80);
    wait_drained();

    write_reg(RegInvHalfSupport, 32'd1);
    write_reg(RegNormFactor, 32'd0);
    write_reg(RegGradFactor, 32'd0);
    write_reg(RegUnused, $urandom());
    cfg_we <= 1'b0;
    add_random(60);
    wait_drained();

    write_reg(RegInvHalfSupport, 32'hFFFF_FFFF);
    write_reg(RegNormFactor, $urandom());
    write_reg(RegGradFactor, $urandom());
    cfg_we <= 1'b0;
    add_random(60);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(RegInvHalfSupport, $urandom_range(32'h1000, 32'h10_0000));
      write_reg(RegNormFactor, $urandom() >> $urandom_range(0, 16));
      write_reg(RegGradFactor, $urandom() >> $urandom_range(0, 16));
      if (phase % 3 == 0) write_reg(RegUnused, $urandom());
      cfg_we <= 1'b0;
      if (phase == 7) gaps_on = 1'b0;
      add_random(80);
      wait_drained();
    end

    if (fault_count == 0 && kernel_q.size() == 0) begin
      $display("sph_cubic_spline_kernel_unit: match");
    end else begin
      $display("sph_cubic_spline_kernel_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sphk_pkg.sv
sv/sphk_pow.sv
sv/sphk_fac.sv
sv/sphk_grad.sv
sv/sph_cubic_spline_kernel_unit.sv
test/sph_cubic_spline_kernel_unit_test.sv
